// ----- rtl/prefix_trie_window_match_count_defines.svh -----
// assertion macros for the prefix trie block
`ifndef PREFIX_TRIE_WINDOW_MATCH_COUNT_DEFINES_SVH
`define PREFIX_TRIE_WINDOW_MATCH_COUNT_DEFINES_SVH

// same-cycle implication
`define PTWMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTWMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ptwmc_pkg.sv -----
`default_nettype none
package ptwmc_pkg;
    localparam int NODE_COUNT     = 65536;
    localparam int NODE_BITS      = $clog2(NODE_COUNT);
    localparam int USED_BITS      = NODE_BITS + 1;
    localparam int RULE_BITS      = 20;
    localparam int ADDR_BITS      = 32;
    localparam int TOP_BIT        = 31;
    localparam int LEN_BITS       = 6;
    localparam int STACK_SLOTS    = 32;
    localparam int STACK_IDX_BITS = $clog2(STACK_SLOTS);
    localparam int DEPTH_BITS     = STACK_IDX_BITS + 1;
    localparam int COUNT_BITS     = 6;
    localparam int STATUS_BITS    = 2;

    localparam logic [RULE_BITS-1:0] RULE_MAX = {RULE_BITS{1'b1}};
    localparam logic [USED_BITS-1:0] USED_MAX = USED_BITS'(NODE_COUNT - 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_POOL_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RULES_OUT = 2'd2;

    typedef logic [NODE_BITS-1:0]   node_t;
    typedef logic [2*NODE_BITS-1:0] child_word_t;
    typedef logic [RULE_BITS-1:0]   rule_t;
endpackage
`default_nettype wire

// ----- rtl/prefix_trie_window_match_count.sv -----
// steps: a query walks each trie level through S_QSTEP and S_QREAD, handling tagged nodes
// and stack pops in S_QSTEP; an insert walks existing levels through S_IWALK and S_IREAD,
// checks the pool in S_ICHECK, adds one node per S_IBUILD pass and tags the final node in
// S_IFIN; a dropped insert is shorter; one item at a time: busy falls with the done strobe
// and the next start beat can be taken at the end of that cycle; the receiver cannot stall
// reset clears control state, counters and root links; pool entries are zeroed on allocation
`default_nettype none
module prefix_trie_window_match_count
    import ptwmc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   cmd,
    input  wire logic [ADDR_BITS-1:0]   addr,
    input  wire logic [LEN_BITS-1:0]    prefix_len,
    input  wire logic [RULE_BITS-1:0]   window_lo,
    input  wire logic [RULE_BITS-1:0]   window_hi,
    output logic                        done,
    output logic [COUNT_BITS-1:0]       match_count,
    output logic [STATUS_BITS-1:0]      status
);
`include "prefix_trie_window_match_count_defines.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_QSTEP  = 3'd1;
    localparam logic [2:0] S_QREAD  = 3'd2;
    localparam logic [2:0] S_IWALK  = 3'd3;
    localparam logic [2:0] S_IREAD  = 3'd4;
    localparam logic [2:0] S_ICHECK = 3'd5;
    localparam logic [2:0] S_IBUILD = 3'd6;
    localparam logic [2:0] S_IFIN   = 3'd7;

    localparam logic [LEN_BITS-1:0] FULL_LEN = LEN_BITS'(TOP_BIT + 1);

    // trie pool
    child_word_t child_mem [NODE_COUNT];
    rule_t       tag_mem   [NODE_COUNT];
    child_word_t rd_word_reg;
    rule_t       rd_tag_reg;

    logic                  child_we;
    node_t                 child_waddr;
    child_word_t           child_wdata;
    logic                  tag_we;
    node_t                 tag_waddr;
    rule_t                 tag_wdata;

    // match stack
    rule_t stack_reg [STACK_SLOTS];
    logic  flag_reg  [STACK_SLOTS];
    logic  push_en;

    logic [2:0]             state_reg, state_next;
    node_t                  root_c0_reg, root_c0_next;
    node_t                  root_c1_reg, root_c1_next;
    logic [USED_BITS-1:0]   used_reg, used_next;
    rule_t                  rule_cnt_reg, rule_cnt_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    node_t                  node_reg, node_next;
    logic [LEN_BITS-1:0]    level_reg, level_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    rule_t                  lo_reg, lo_next;
    rule_t                  hi_reg, hi_next;
    logic                   tag_done_reg, tag_done_next;
    logic                   first_reg, first_next;
    logic                   done_reg, done_next;
    logic [COUNT_BITS-1:0]  mcount_reg, mcount_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;

    child_word_t              cur_word;
    node_t                    child_sel;
    logic                     bit_sel;
    logic [STACK_IDX_BITS-1:0] top_idx;
    rule_t                    top_val;
    logic                     in_win;
    logic [LEN_BITS-1:0]      need;
    logic [USED_BITS-1:0]     used_sum;
    node_t                    new_node;
    node_t                    other_child;

    assign cur_word    = (node_reg == '0) ? {root_c1_reg, root_c0_reg} : rd_word_reg;
    assign bit_sel     = addr_reg[TOP_BIT];
    assign child_sel   = bit_sel ? cur_word[2*NODE_BITS-1:NODE_BITS] : cur_word[NODE_BITS-1:0];
    assign top_idx     = STACK_IDX_BITS'(depth_reg - DEPTH_BITS'(1));
    assign top_val     = stack_reg[top_idx];
    assign in_win      = (lo_reg <= rd_tag_reg) && (rd_tag_reg <= hi_reg);
    assign need        = len_reg - level_reg;
    assign used_sum    = used_reg + USED_BITS'(need);
    assign new_node    = NODE_BITS'(used_reg + USED_BITS'(1));
    assign other_child = first_reg
                         ? (bit_sel ? cur_word[NODE_BITS-1:0] : cur_word[2*NODE_BITS-1:NODE_BITS])
                         : '0;

    always_comb
    begin
        state_next    = state_reg;
        root_c0_next  = root_c0_reg;
        root_c1_next  = root_c1_reg;
        used_next     = used_reg;
        rule_cnt_next = rule_cnt_reg;
        depth_next    = depth_reg;
        count_next    = count_reg;
        node_next     = node_reg;
        level_next    = level_reg;
        len_next      = len_reg;
        addr_next     = addr_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        tag_done_next = tag_done_reg;
        first_next    = first_reg;
        done_next     = 1'b0;
        mcount_next   = mcount_reg;
        status_next   = status_reg;
        child_we      = 1'b0;
        child_waddr   = node_reg;
        child_wdata   = '0;
        tag_we        = 1'b0;
        tag_waddr     = node_reg;
        tag_wdata     = '0;
        push_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    addr_next     = addr;
                    lo_next       = window_lo;
                    hi_next       = window_hi;
                    len_next      = (prefix_len > FULL_LEN) ? FULL_LEN : prefix_len;
                    node_next     = '0;
                    level_next    = '0;
                    depth_next    = '0;
                    count_next    = '0;
                    tag_done_next = 1'b0;
                    if (cmd == CMD_QUERY)
                    begin
                        state_next = S_QSTEP;
                    end
                    else if (rule_cnt_reg == RULE_MAX)
                    begin
                        done_next   = 1'b1;
                        mcount_next = '0;
                        status_next = STATUS_RULES_OUT;
                    end
                    else
                    begin
                        state_next = S_IWALK;
                    end
                end
            end
            S_QSTEP:
            begin
                if (node_reg != '0 && !tag_done_reg && rd_tag_reg != '0)
                begin
                    if (depth_reg != '0 && rd_tag_reg < top_val)
                    begin
                        depth_next = depth_reg - DEPTH_BITS'(1);
                        count_next = count_reg - COUNT_BITS'(flag_reg[top_idx]);
                    end
                    else
                    begin
                        tag_done_next = 1'b1;
                        if (depth_reg < DEPTH_BITS'(STACK_SLOTS))
                        begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + DEPTH_BITS'(1);
                            count_next = count_reg + COUNT_BITS'(in_win);
                        end
                    end
                end
                else if (level_reg == FULL_LEN || child_sel == '0)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    mcount_next = count_reg;
                    status_next = STATUS_OK;
                end
                else
                begin
                    node_next     = child_sel;
                    level_next    = level_reg + LEN_BITS'(1);
                    addr_next     = addr_reg << 1;
                    tag_done_next = 1'b0;
                    state_next    = S_QREAD;
                end
            end
            S_QREAD:
            begin
                state_next = S_QSTEP;
            end
            S_IWALK:
            begin
                if (level_reg == len_reg || child_sel == '0)
                begin
                    state_next = S_ICHECK;
                end
                else
                begin
                    node_next  = child_sel;
                    level_next = level_reg + LEN_BITS'(1);
                    addr_next  = addr_reg << 1;
                    state_next = S_IREAD;
                end
            end
            S_IREAD:
            begin
                state_next = S_IWALK;
            end
            S_ICHECK:
            begin
                first_next = 1'b1;
                if (used_sum > USED_MAX)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    mcount_next = '0;
                    status_next = STATUS_POOL_FULL;
                end
                else if (need == '0)
                begin
                    state_next = S_IFIN;
                end
                else
                begin
                    state_next = S_IBUILD;
                end
            end
            S_IBUILD:
            begin
                // link the new node under the current one
                if (node_reg == '0)
                begin
                    if (bit_sel)
                    begin
                        root_c1_next = new_node;
                    end
                    else
                    begin
                        root_c0_next = new_node;
                    end
                end
                else
                begin
                    child_we    = 1'b1;
                    child_wdata = bit_sel ? {new_node, other_child} : {other_child, new_node};
                end
                tag_we     = 1'b1;
                tag_waddr  = new_node;
                tag_wdata  = '0;
                used_next  = used_reg + USED_BITS'(1);
                node_next  = new_node;
                level_next = level_reg + LEN_BITS'(1);
                addr_next  = addr_reg << 1;
                first_next = 1'b0;
                if (level_reg + LEN_BITS'(1) == len_reg)
                begin
                    state_next = S_IFIN;
                end
            end
            S_IFIN:
            begin
                if (node_reg != '0)
                begin
                    tag_we    = 1'b1;
                    tag_wdata = rule_cnt_reg + RULE_BITS'(1);
                    child_we  = !first_reg;
                end
                rule_cnt_next = rule_cnt_reg + RULE_BITS'(1);
                state_next    = S_IDLE;
                done_next     = 1'b1;
                mcount_next   = '0;
                status_next   = STATUS_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            root_c0_reg  <= '0;
            root_c1_reg  <= '0;
            used_reg     <= '0;
            rule_cnt_reg <= '0;
            depth_reg    <= '0;
            count_reg    <= '0;
            tag_done_reg <= 1'b0;
            first_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            root_c0_reg  <= root_c0_next;
            root_c1_reg  <= root_c1_next;
            used_reg     <= used_next;
            rule_cnt_reg <= rule_cnt_next;
            depth_reg    <= depth_next;
            count_reg    <= count_next;
            tag_done_reg <= tag_done_next;
            first_reg    <= first_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        level_reg  <= level_next;
        len_reg    <= len_next;
        addr_reg   <= addr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mcount_reg <= mcount_next;
        status_reg <= status_next;
        if (push_en)
        begin
            stack_reg[depth_reg[STACK_IDX_BITS-1:0]] <= rd_tag_reg;
            flag_reg[depth_reg[STACK_IDX_BITS-1:0]]  <= in_win;
        end
    end

    // pool memories
    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        rd_word_reg <= child_mem[node_next];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        rd_tag_reg <= tag_mem[node_next];
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign match_count = mcount_reg;
    assign status      = status_reg;

    `PTWMC_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result beat while busy")
    `PTWMC_ASSERT_NOW(a_count_le_depth, 1'b1, count_reg <= COUNT_BITS'(depth_reg), "count above stack depth")
    `PTWMC_ASSERT_NOW(a_fail_no_count, done_reg && status_reg != STATUS_OK, mcount_reg == '0, "failed insert with count")
    `PTWMC_ASSERT_NEXT(a_pool_bound, 1'b1, used_reg <= USED_MAX, "node pool overrun")

endmodule
`default_nettype wire
